// ===== hdl/rrsdf_pkg.sv =====
// Shared types, constants and helpers for the rounded-rectangle blender.
package rrsdf_pkg;

	localparam int CoordBits = 12;
	localparam int FracBits  = 4;

	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_RADIUS = 3'd4,
		REG_STROKE = 3'd5,
		REG_COLOR  = 3'd6,
		REG_ALPHA  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [23:0] dest_color;
	} pix_in_t;

	typedef struct packed {
		logic        write_pixel;
		logic [23:0] new_color;
	} pix_out_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_wr_t;

	// x / 255 for x < 65280, exact: (x*257 + 257) >> 16
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [32:0] p;
		p = {17'd0, x} * 33'd257 + 33'd257;
		return p[23:16];
	endfunction

endpackage

// ===== hdl/rounded_rect_sdf_blender.sv =====
// Top level of the rounded-rectangle coverage blender.
// Usage:
//  in_* channel: one framebuffer pixel per transaction (column, row, colour).
//  out_* channel: one result per input transaction, write flag and colour.
//  cfg_* channel: register writes (index, data), taken any time; only
//  write while the pipeline is empty.
// Throughput: one pixel per clock while the receiver keeps taking results;
//  the five-stage square-root unit sets the depth of the pipeline.
// All stages advance together: while the output register holds a result
//  the receiver has not taken, the whole pipeline holds; input ready is
//  high whenever the output slot is empty or being drained.
// Reset clears all valid bits and sets registers to their reset values
//  (alpha 255, all others zero).
module rounded_rect_sdf_blender (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rrsdf_pkg::pix_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rrsdf_pkg::pix_out_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  rrsdf_pkg::cfg_wr_t   cfg_data
);
	import rrsdf_pkg::*;

	localparam int One  = 1 << FracBits;
	localparam int Half = One >> 1;
	localparam int SqDepth = 5;

	// configuration registers
	logic signed [15:0] left_q, top_q;
	logic [15:0] width_q, height_q, radius_q, stroke_q;
	logic [23:0] color_q;
	logic [7:0]  alpha_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0; top_q <= '0; width_q <= '0; height_q <= '0;
			radius_q <= '0; stroke_q <= '0; color_q <= '0; alpha_q <= 8'd255;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_data.index))
				REG_LEFT:   left_q   <= cfg_data.data[15:0];
				REG_TOP:    top_q    <= cfg_data.data[15:0];
				REG_WIDTH:  width_q  <= cfg_data.data[15:0];
				REG_HEIGHT: height_q <= cfg_data.data[15:0];
				REG_RADIUS: radius_q <= cfg_data.data[15:0];
				REG_STROKE: stroke_q <= cfg_data.data[15:0];
				REG_COLOR:  color_q  <= cfg_data.data[23:0];
				REG_ALPHA:  alpha_q  <= cfg_data.data[7:0];
				default: ;
			endcase
		end
	end

	// one global advance: stall the whole pipe when the output is blocked
	logic advance;
	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	// mode decode (static between items)
	logic is_fill, hard_box, big_enough;
	logic [15:0] sw_eff;
	assign is_fill    = (stroke_q == '0);
	assign hard_box   = is_fill && (radius_q <= 16'(Half));
	assign big_enough = (width_q >= 16'(One)) && (height_q >= 16'(One)) && (alpha_q != '0);
	assign sw_eff     = (stroke_q < 16'(One)) ? 16'(One) : stroke_q;

	// stage 1: bounds, axis offsets
	logic        v_s1, inbox_s1, sdf_s1;
	logic [23:0] dest_s1;
	logic signed [20:0] ax_s1, ay_s1;
	logic signed [20:0] pfx, pfy, lx, ty, bx, by, cx, cy;
	logic inhard, inround;
	always_comb begin
		pfx = 21'(signed'({1'b0, in_data.pixel_x[CoordBits-1:0]})) <<< FracBits;
		pfy = 21'(signed'({1'b0, in_data.pixel_y[CoordBits-1:0]})) <<< FracBits;
		lx  = 21'(left_q);
		ty  = 21'(top_q);
		bx  = lx + 21'(signed'({1'b0, width_q}));
		by  = ty + 21'(signed'({1'b0, height_q}));
		inhard = (pfx + One > lx) && (pfy + One > ty) &&
			(pfx + One <= bx + Half) && (pfy + One <= by + Half);
		inround = (pfx + One > lx) && (pfy + One > ty) && (pfx < bx) && (pfy < by);
		cx = 21'((pfx <<< 1) + One - ((lx <<< 1) + 21'(signed'({1'b0, width_q}))));
		cy = 21'((pfy <<< 1) + One - ((ty <<< 1) + 21'(signed'({1'b0, height_q}))));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (advance) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_s1  <= in_data.dest_color;
			inbox_s1 <= big_enough && (hard_box ? inhard : inround);
			sdf_s1   <= !hard_box;
			ax_s1    <= (cx < 0) ? -cx : cx;
			ay_s1    <= (cy < 0) ? -cy : cy;
		end
	end

	// stage 2: dx, dy, clamp, inner term
	logic        v_s2, inbox_s2, sdf_s2;
	logic [23:0] dest_s2;
	logic [19:0] ox_s2, oy_s2;
	logic signed [20:0] in_s2;
	logic signed [20:0] dx, dy;
	always_comb begin
		dx = ax_s1 - (21'(signed'({1'b0, width_q}))  - (21'(signed'({1'b0, radius_q})) <<< 1));
		dy = ay_s1 - (21'(signed'({1'b0, height_q})) - (21'(signed'({1'b0, radius_q})) <<< 1));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (advance) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_s2 <= dest_s1; inbox_s2 <= inbox_s1; sdf_s2 <= sdf_s1;
			ox_s2 <= (dx > 0) ? dx[19:0] : '0;
			oy_s2 <= (dy > 0) ? dy[19:0] : '0;
			in_s2 <= (dx > dy) ? ((dx > 0) ? '0 : dx) : ((dy > 0) ? '0 : dy);
		end
	end

	// stage 3: squares
	logic        v_s3, inbox_s3, sdf_s3;
	logic [23:0] dest_s3;
	logic [39:0] sq_s3;
	logic signed [20:0] in_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (advance) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_s3 <= dest_s2; inbox_s3 <= inbox_s2; sdf_s3 <= sdf_s2; in_s3 <= in_s2;
			sq_s3 <= {20'd0, ox_s2} * {20'd0, ox_s2} + {20'd0, oy_s2} * {20'd0, oy_s2};
		end
	end

	// stages 4..8: square root, side data in a delay line
	logic [19:0] root;
	rrsdf_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.radicand (sq_s3),
		.root     (root)
	);

	logic        v_d    [SqDepth];
	logic        inbox_d[SqDepth];
	logic        sdf_d  [SqDepth];
	logic [23:0] dest_d [SqDepth];
	logic signed [20:0] in_d[SqDepth];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SqDepth; i++) v_d[i] <= 1'b0;
		end else if (advance) begin
			v_d[0] <= v_s3;
			for (int i = 1; i < SqDepth; i++) v_d[i] <= v_d[i-1];
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			inbox_d[0] <= inbox_s3; sdf_d[0] <= sdf_s3;
			dest_d[0] <= dest_s3; in_d[0] <= in_s3;
			for (int i = 1; i < SqDepth; i++) begin
				inbox_d[i] <= inbox_d[i-1]; sdf_d[i] <= sdf_d[i-1];
				dest_d[i] <= dest_d[i-1]; in_d[i] <= in_d[i-1];
			end
		end
	end

	// stage 9: distance to alpha
	logic        v_s9, wr_s9;
	logic [23:0] dest_s9;
	logic [7:0]  a_s9;
	logic signed [22:0] d2, cov2;
	logic [8:0]  cov8;
	logic [16:0] am;
	logic [7:0]  a_calc;
	always_comb begin
		d2 = 23'(signed'({1'b0, root})) + 23'(in_d[SqDepth-1])
			- 23'(signed'({1'b0, radius_q, 1'b0}));
		if (!is_fill) d2 = ((d2 < 0) ? -d2 : d2) - 23'(signed'({1'b0, sw_eff}));
		cov2 = 23'(One) - d2;
		if (cov2 < 0) cov2 = '0;
		if (cov2 > 23'(2 * One)) cov2 = 23'(2 * One);
		cov8 = 9'(((18'(cov2[FracBits+1:0]) << 8) + 18'(One)) >> (FracBits + 1));
		am = {9'd0, alpha_q} * {8'd0, cov8} + 17'd128;
		a_calc = !inbox_d[SqDepth-1] ? 8'd0 :
			(sdf_d[SqDepth-1] ? am[15:8] : alpha_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (advance) v_s9 <= v_d[SqDepth-1];
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_s9 <= dest_d[SqDepth-1];
			a_s9    <= a_calc;
			wr_s9   <= (a_calc != '0);
		end
	end

	// output register: blend
	logic [23:0] mix;
	always_comb begin
		for (int c = 0; c < 3; c++)
			mix[c*8 +: 8] = div255({8'd0, color_q[c*8 +: 8]} * {8'd0, a_s9} +
				{8'd0, dest_s9[c*8 +: 8]} * {8'd0, 8'd255 - a_s9});
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (advance) out_valid <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.write_pixel <= wr_s9;
			out_data.new_color   <= !wr_s9 ? dest_s9 :
				((a_s9 == 8'd255) ? color_q : mix);
		end
	end
endmodule

// ===== hdl/rrsdf_isqrt.sv =====
// Pipelined integer square root, one result bit per step.
module rrsdf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic [39:0] radicand,
	output logic [19:0] root
);
	import rrsdf_pkg::*;

	localparam int Steps = 20;

	logic [39:0] rem_q  [Steps+1];
	logic [19:0] res_q  [Steps+1];

	assign rem_q[0] = radicand;
	assign res_q[0] = '0;

	for (genvar i = 0; i < Steps; i++) begin : g_step
		logic [41:0] trial;
		logic [41:0] remw;
		logic [39:0] rem_n;
		logic [19:0] res_n;
		always_comb begin
			trial = {20'd0, res_q[i], 2'b01} << (2 * (Steps - 1 - i));
			remw  = {2'b00, rem_q[i]};
			if (remw >= trial) begin
				rem_n = 40'(remw - trial);
				res_n = {res_q[i][18:0], 1'b1};
			end else begin
				rem_n = rem_q[i];
				res_n = {res_q[i][18:0], 1'b0};
			end
		end
		// only every fourth step registers
		if ((i % 4) == 3) begin : g_reg
			logic [39:0] rem_r;
			logic [19:0] res_r;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rem_r <= '0;
					res_r <= '0;
				end else if (advance) begin
					rem_r <= rem_n;
					res_r <= res_n;
				end
			end
			assign rem_q[i+1] = rem_r;
			assign res_q[i+1] = res_r;
		end else begin : g_comb
			assign rem_q[i+1] = rem_n;
			assign res_q[i+1] = res_n;
		end
	end

	assign root = res_q[Steps];
endmodule

// ===== test/rounded_rect_sdf_blender_tb.sv =====
// Self-checking testbench for the rounded-rectangle coverage blender.
`timescale 1ns / 100ps

module rounded_rect_sdf_blender_tb;
	import rrsdf_pkg::*;

	// Register copy, expected-colour queue and mismatch count.
	class blend_scoreboard;
		logic [31:0] regs [8];
		pix_out_t    expected_q [$];
		int          errors;
		int          pixels;
		int          writes;

		function new();
			foreach (regs[i]) regs[i] = '0;
			regs[REG_ALPHA] = 32'd255;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] val);
			regs[idx] = val;
		endfunction

		static function longint root_floor(longint v);
			longint res, bit_w;
			res = 0;
			bit_w = longint'(1) << 62;
			while (bit_w > v) bit_w = bit_w >> 2;
			while (bit_w != 0) begin
				if (v >= res + bit_w) begin
					v = v - (res + bit_w);
					res = (res >> 1) + bit_w;
				end else begin
					res = res >> 1;
				end
				bit_w = bit_w >> 2;
			end
			return res;
		endfunction

		static function longint mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Coverage alpha for one pixel under the current registers.
		function int pixel_alpha(logic [11:0] px, logic [11:0] py);
			longint one, half, l, t, w, h, r, sw, pfx, pfy, dx, dy, ox, oy, inner;
			longint d2, cov2, cov8, alpha;
			one   = longint'(1) << FracBits;
			half  = one >> 1;
			l     = longint'($signed(regs[REG_LEFT][15:0]));
			t     = longint'($signed(regs[REG_TOP][15:0]));
			w     = longint'(regs[REG_WIDTH][15:0]);
			h     = longint'(regs[REG_HEIGHT][15:0]);
			r     = longint'(regs[REG_RADIUS][15:0]);
			sw    = longint'(regs[REG_STROKE][15:0]);
			alpha = longint'(regs[REG_ALPHA][7:0]);
			pfx   = longint'(px) * one;
			pfy   = longint'(py) * one;
			if (w < one || h < one || alpha == 0) return 0;
			if (sw == 0 && r <= half) begin
				// hard box: no antialiasing, whole opacity
				if (pfx + one > l && pfy + one > t &&
				    pfx + one <= l + w + half && pfy + one <= t + h + half)
					return int'(alpha);
				return 0;
			end
			if (!(pfx + one > l && pfy + one > t && pfx < l + w && pfy < t + h))
				return 0;
			dx = mag(2 * pfx + one - (2 * l + w)) - (w - 2 * r);
			dy = mag(2 * pfy + one - (2 * t + h)) - (h - 2 * r);
			ox = dx > 0 ? dx : 0;
			oy = dy > 0 ? dy : 0;
			inner = dx > dy ? dx : dy;
			if (inner > 0) inner = 0;
			d2 = root_floor(ox * ox + oy * oy) + inner - 2 * r;
			if (sw != 0) begin
				if (sw < one) sw = one;
				d2 = mag(d2) - sw;
			end
			cov2 = one - d2;
			if (cov2 < 0) cov2 = 0;
			if (cov2 > 2 * one) cov2 = 2 * one;
			cov8 = (cov2 * 256 + one) >> (FracBits + 1);
			return int'((alpha * cov8 + 128) >> 8);
		endfunction

		function void note_pixel(pix_in_t p);
			pix_out_t e;
			int a, sc, dc;
			a = pixel_alpha(p.pixel_x, p.pixel_y);
			e.write_pixel = (a != 0);
			e.new_color = p.dest_color;
			if (a >= 255) begin
				e.new_color = regs[REG_COLOR][23:0];
			end else if (a != 0) begin
				for (int sh = 0; sh < 24; sh += 8) begin
					sc = int'(regs[REG_COLOR][sh +: 8]);
					dc = int'(p.dest_color[sh +: 8]);
					e.new_color[sh +: 8] = 8'((sc * a + dc * (255 - a)) / 255);
				end
			end
			expected_q.push_back(e);
			pixels++;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(pix_out_t o);
			pix_out_t e;
			if (expected_q.size() == 0) begin
				report("result with no pixel outstanding");
				return;
			end
			e = expected_q.pop_front();
			if (o.write_pixel) writes++;
			if (o.write_pixel !== e.write_pixel)
				report($sformatf("write_pixel %b, want %b", o.write_pixel, e.write_pixel));
			if (o.new_color !== e.new_color)
				report($sformatf("new_color %h, want %h", o.new_color, e.new_color));
		endtask
	endclass

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	pix_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pix_out_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_wr_t  cfg_data  = '0;

	blend_scoreboard sb = new();
	int  cfg_writes;
	bit  no_gaps;   // phases with back-to-back transactions

	rounded_rect_sdf_blender i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drop input valid, then hold off until every outstanding pixel is back
	// and the pipe has drained.
	task wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write one register; call from a rising edge with the pipe idle.
	task write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_data  <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		cfg_writes++;
	endtask

	task write_shape(int l, int t, int w, int h, int r, int sw, int col, int al);
		write_reg(REG_LEFT, l);
		write_reg(REG_TOP, t);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_RADIUS, r);
		write_reg(REG_STROKE, sw);
		write_reg(REG_COLOR, col);
		write_reg(REG_ALPHA, al);
	endtask

	// Present one pixel, after a random gap unless no_gaps is set, and advance once it is taken.
	task send_pixel(int x, int y, int col);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{pixel_x: x[11:0], pixel_y: y[11:0], dest_color: col[23:0]};
		do @(posedge clk); while (!in_ready);
		sb.note_pixel('{pixel_x: x[11:0], pixel_y: y[11:0], dest_color: col[23:0]});
	endtask

	function int pick_edge(int lo, int hi);
		case ($urandom_range(0, 9))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(0, 1) ? lo + $urandom_range(0, 64)
			                                      : $urandom_range(0, 2000);
		endcase
	endfunction

	// Random register setting; mostly a visible shape, sometimes extremes.
	task random_setting();
		int l, t, w, h, r, sw, al;
		l = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? -32768 : 32767)
		                              : $urandom_range(0, 1600) - 100;
		t = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? -32768 : 32767)
		                              : $urandom_range(0, 1600) - 100;
		w = pick_edge(0, 65535);
		h = pick_edge(0, 65535);
		if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 20);
		case ($urandom_range(0, 3))
			0:       r = $urandom_range(0, 8);
			1:       r = 65535;
			default: r = $urandom_range(0, (w < h ? w : h) / 2 + 8);
		endcase
		case ($urandom_range(0, 3))
			0:       sw = 65535;
			1:       sw = $urandom_range(1, 64);
			default: sw = 0;
		endcase
		case ($urandom_range(0, 3))
			0:       al = 255;
			1:       al = $urandom_range(0, 1) ? 0 : 1;
			default: al = $urandom_range(0, 255);
		endcase
		write_shape(l, t, w, h, r, sw, $urandom, al);
	endtask

	// Mostly pixels around the shape, the rest anywhere in the coordinate range.
	function int near_coord(int edge_q4, int ext_q4);
		int c;
		c = (edge_q4 >>> 4) - 3 + $urandom_range(0, (ext_q4 >>> 4) + 6);
		if (c < 0 || c > 4095 || $urandom_range(0, 7) == 0) c = $urandom_range(0, 4095);
		return c;
	endfunction

	initial begin
		int l, t, w, h;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at reset value: width zero, nothing may be written.
		no_gaps = 1'b1;
		send_pixel(0, 0, 24'h123456);
		send_pixel(4095, 4095, 24'hffffff);
		wait_idle();

		// Hard box at (10,5) size 20x12: probe both sides of every edge.
		write_shape(160, 80, 320, 192, 8, 0, 24'hff8000, 255);
		no_gaps = 1'b0;
		send_pixel(9, 10, 24'h000000);
		send_pixel(10, 10, 24'h000000);
		send_pixel(29, 16, 24'hffffff);
		send_pixel(30, 16, 24'hffffff);
		send_pixel(15, 4, 24'h00ff00);
		send_pixel(15, 5, 24'h00ff00);
		send_pixel(15, 16, 24'h0000ff);
		send_pixel(15, 17, 24'h0000ff);
		wait_idle();

		// Rounded fill with half opacity: corners give partial coverage.
		write_shape(-24, 8, 400, 240, 96, 0, 24'h80ff40, 128);
		send_pixel(0, 1, 24'h102030);
		send_pixel(1, 1, 24'h102030);
		send_pixel(10, 8, 24'hffffff);
		send_pixel(23, 15, 24'h000000);
		wait_idle();

		// Thin stroke raised to one pixel, then a stroke at extreme width.
		write_shape(32, 32, 320, 320, 40, 3, 24'h00ffff, 255);
		send_pixel(2, 10, 24'h400000);
		send_pixel(10, 10, 24'h400000);
		send_pixel(21, 2, 24'h400000);
		wait_idle();
		write_reg(REG_STROKE, 65535);
		send_pixel(10, 10, 24'habcdef);
		send_pixel(0, 0, 24'habcdef);
		wait_idle();

		// Opacity zero disables all writes; radius at maximum.
		write_shape(0, 0, 65535, 65535, 65535, 0, 24'hffffff, 0);
		send_pixel(100, 100, 24'h5a5a5a);
		wait_idle();
		write_reg(REG_ALPHA, 255);
		send_pixel(100, 100, 24'h5a5a5a);
		send_pixel(4095, 0, 24'ha5a5a5);
		wait_idle();

		// Random phases: each draws fresh registers and about fifty pixels.
		for (int ph = 0; ph < 8; ph++) begin
			random_setting();
			no_gaps = (ph % 3 == 1);
			l = $signed(sb.regs[REG_LEFT][15:0]);
			t = $signed(sb.regs[REG_TOP][15:0]);
			w = sb.regs[REG_WIDTH][15:0];
			h = sb.regs[REG_HEIGHT][15:0];
			if (w > 800) w = 800;
			if (h > 800) h = 800;
			for (int n = 0; n < 48; n++)
				send_pixel(near_coord(l, w), near_coord(t, h), $urandom);
			wait_idle();
		end

		$display("covered %0d pixels (%0d written) over %0d register writes",
		         sb.pixels, sb.writes, cfg_writes);
		$display("fill, hard box, rounded corners, stroke and zero opacity exercised");
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Receiver: unless no_gaps is set, stall a random number of cycles before taking each result.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_data);
		end
	end

	initial begin
		#5000000;
		$display("timeout at %0t", $time);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
